// File: design/cwtg_pkg.sv
// Package for the caption window text grid: sizes, codes, state encoding.
// Used by caption_window_text_grid; no dependencies.
package cwtg_pkg;
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 64;
    localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ATTR_W      = 39;
    localparam int CHAR_W      = 16;
    localparam int CELL_W      = CHAR_W + ATTR_W;

    localparam logic [15:0] CODE_CR  = 16'h000D;
    localparam logic [15:0] CODE_HCR = 16'h000E;
    localparam logic [15:0] CODE_BS  = 16'h0008;
    localparam logic [15:0] CODE_FF  = 16'h000C;
    localparam logic [15:0] SPACE    = 16'h0020;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_PEN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_PRINT  = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd3;
    localparam logic [2:0] REG_LROWS  = 3'd4;
    localparam logic [2:0] REG_LCOLS  = 3'd5;
    localparam logic [2:0] REG_DEF    = 3'd6;

    localparam logic [1:0] DIR_BT = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,      // reset sweep: write spaces/zero to every cell
        S_IDLE,
        S_DECODE,    // decide what the transaction does
        S_FILL,      // sweep writes space+attr over an address range
        S_ROLL_RD,   // roll: read cell one row below
        S_ROLL_WR,   // roll: write it one row up
        S_MOVE,      // pen move after a printed character or a backspace
        S_BS_BLANK,  // blank the cell at the pen after backspace
        S_PEN,       // place pen after set pen location
        S_READ,      // read data available
        S_OUT
    } t_state;
endpackage

// File: design/caption_window_text_grid.sv
// Caption window text grid: character/attribute memory, pen and sequencer.
// Depends on cwtg_pkg.
//
// Usage: configuration writes on i_cfg_* (index 0..6) while idle. Items arrive
// on the s_axis channel, one result per item leaves on m_axis.
// The grid lives in one single-port memory of 1024 cells; one memory access
// per cycle sets the timing. After reset a clearing pass writes spaces with
// zero attribute; s_axis_tready stays low during it.
// A horizontal return, a clear, a form feed and a roll each sweep their cells
// one memory access at a time; a roll copies each row up and blanks the last.
// The next item is taken once the result has been accepted, so a stalled
// receiver holds the block with its result steady.
module caption_window_text_grid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: char_code[15:0], pen_attribute[54:16], target_row[58:55],
    // target_column[64:59], zero pad
    input  logic [71:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cell_character[15:0], cell_attribute[54:16], pen_row_now[59:55],
    // pen_column_now[65:60], grid_changed[66], zero pad
    output logic [71:0] m_axis_tdata
);
    localparam int AW = cwtg_pkg::ADDR_W;
    localparam int RW = cwtg_pkg::ROW_W;
    localparam int CW = cwtg_pkg::COL_W;

    logic [cwtg_pkg::CELL_W-1:0] mem [cwtg_pkg::CELLS];
    logic [cwtg_pkg::CELL_W-1:0] r_rdata;

    cwtg_pkg::t_state r_state, n_state;

    logic [4:0] r_vrows;
    logic [6:0] r_vcols;
    logic [1:0] r_print, r_scroll;
    logic       r_lrows, r_lcols, r_def;

    logic [4:0] r_pen_row, n_pen_row;
    logic [5:0] r_pen_col, n_pen_col;

    logic [1:0]  r_kind;
    logic [15:0] r_code;
    logic [cwtg_pkg::ATTR_W-1:0] r_attr;
    logic [RW-1:0] r_trow;
    logic [CW-1:0] r_tcol;

    // sweep: address counter and end
    logic [AW:0] r_addr, n_addr;
    logic [AW:0] r_end, n_end;
    logic [RW:0] r_rr, n_rr;   // roll row counter
    logic [CW:0] r_rc, n_rc;   // roll column counter
    logic        r_chg, n_chg;
    logic        r_after_roll, n_after_roll; // pen action after roll: 0 move,1 pen
    logic        r_bs, n_bs;
    logic [15:0] r_ochar, n_ochar;
    logic [cwtg_pkg::ATTR_W-1:0] r_oattr, n_oattr;

    // memory port
    logic        m_we;
    logic [AW-1:0] m_addr;
    logic [cwtg_pkg::CELL_W-1:0] m_wdata;

    // saturated size
    logic [4:0] rr_u;
    logic [6:0] cc_u;
    always_comb begin
        rr_u = (r_vrows == 5'd0) ? 5'd1 : (r_vrows > 5'(cwtg_pkg::MAX_ROWS)) ?
               5'(cwtg_pkg::MAX_ROWS) : r_vrows;
        cc_u = (r_vcols == 7'd0) ? 7'd1 : (r_vcols > 7'(cwtg_pkg::MAX_COLUMNS)) ?
               7'(cwtg_pkg::MAX_COLUMNS) : r_vcols;
    end

    logic scroll_bt;
    assign scroll_bt = (r_scroll == cwtg_pkg::DIR_BT);

    // pen move computation (signed small ints)
    logic signed [7:0] mv_r, mv_c, lim_r, lim_c;
    logic              mv_roll;
    always_comb begin
        mv_r = $signed({3'd0, r_pen_row});
        mv_c = $signed({2'd0, r_pen_col});
        mv_roll = 1'b0;
        unique case (r_print)
            2'd0: mv_c = r_bs ? mv_c - 8'sd1 : mv_c + 8'sd1;
            2'd1: mv_c = r_bs ? mv_c + 8'sd1 : mv_c - 8'sd1;
            2'd2: mv_r = r_bs ? mv_r - 8'sd1 : mv_r + 8'sd1;
            default: mv_r = r_bs ? mv_r + 8'sd1 : mv_r - 8'sd1;
        endcase
        if (!r_print[1]) begin
            if (!r_lrows && r_lcols) begin
                if (mv_c >= $signed({1'b0, cc_u})) begin
                    mv_c = 8'sd0;
                    mv_r = mv_r + 8'sd1;
                end else if (mv_c < 8'sd0) begin
                    mv_c = $signed({1'b0, cc_u}) - 8'sd1;
                    mv_r = mv_r - 8'sd1;
                end
            end
            if (scroll_bt && mv_r >= $signed({3'd0, rr_u})) begin
                mv_roll = 1'b1;
            end
        end else begin
            if (mv_r < 8'sd0) mv_r = 8'sd0;
            if (mv_c < 8'sd0) mv_c = 8'sd0;
        end
        lim_r = (mv_r < 8'sd0 || mv_r > $signed({3'd0, rr_u}) - 8'sd1) ?
                $signed({3'd0, rr_u}) - 8'sd1 : mv_r;
        lim_c = (mv_c < 8'sd0 || mv_c > $signed({1'b0, cc_u}) - 8'sd1) ?
                $signed({1'b0, cc_u}) - 8'sd1 : mv_c;
    end

    logic [AW-1:0] pen_addr;
    assign pen_addr = AW'(r_pen_row[RW-1:0]) * AW'(cwtg_pkg::MAX_COLUMNS) + AW'(r_pen_col);

    logic [AW:0] rr_base;  // address of row r_rr, column r_rc
    assign rr_base = (AW+1)'(r_rr) * (AW+1)'(cwtg_pkg::MAX_COLUMNS) + (AW+1)'(r_rc);

    logic in_win;
    assign in_win = (r_pen_row < rr_u) && ({1'b0, r_pen_col} < cc_u);

    // config
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vrows <= 5'd15; r_vcols <= 7'd32; r_print <= 2'd0; r_scroll <= 2'd3;
            r_lrows <= 1'b0; r_lcols <= 1'b1; r_def <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cwtg_pkg::REG_ROWS:   r_vrows  <= i_cfg_data[4:0];
                cwtg_pkg::REG_COLS:   r_vcols  <= i_cfg_data;
                cwtg_pkg::REG_PRINT:  r_print  <= i_cfg_data[1:0];
                cwtg_pkg::REG_SCROLL: r_scroll <= i_cfg_data[1:0];
                cwtg_pkg::REG_LROWS:  r_lrows  <= i_cfg_data[0];
                cwtg_pkg::REG_LCOLS:  r_lcols  <= i_cfg_data[0];
                cwtg_pkg::REG_DEF:    r_def    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_code <= s_axis_tdata[15:0];
            r_attr <= s_axis_tdata[54:16];
            r_trow <= s_axis_tdata[58:55];
            r_tcol <= s_axis_tdata[64:59];
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_addr] <= m_wdata;
        r_rdata <= mem[m_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwtg_pkg::S_INIT:
                if (r_addr == r_end) n_state = cwtg_pkg::S_IDLE;
            cwtg_pkg::S_IDLE:
                if (s_axis_tvalid) n_state = cwtg_pkg::S_DECODE;
            cwtg_pkg::S_DECODE: begin
                n_state = cwtg_pkg::S_OUT;
                if (r_kind == cwtg_pkg::KIND_READ) n_state = cwtg_pkg::S_READ;
                else if (r_def) begin
                    if (r_kind == cwtg_pkg::KIND_CLEAR) n_state = cwtg_pkg::S_FILL;
                    else if (r_kind == cwtg_pkg::KIND_PEN) begin
                        if (scroll_bt && (r_trow == '0 || {1'b0, r_trow} >= rr_u))
                            n_state = (rr_u > 5'd1) ? cwtg_pkg::S_ROLL_RD
                                                    : cwtg_pkg::S_FILL;
                        else n_state = cwtg_pkg::S_PEN;
                    end else if (in_win) begin
                        priority if (r_code == cwtg_pkg::CODE_CR) begin
                            if (scroll_bt && r_pen_row + 5'd1 >= rr_u)
                                n_state = (rr_u > 5'd1) ? cwtg_pkg::S_ROLL_RD
                                                        : cwtg_pkg::S_FILL;
                        end else if (r_code == cwtg_pkg::CODE_HCR ||
                                     r_code == cwtg_pkg::CODE_FF) begin
                            n_state = cwtg_pkg::S_FILL;
                        end else begin
                            n_state = cwtg_pkg::S_MOVE;
                        end
                    end
                end
            end
            // a roll out of the move step has the pen set already
            cwtg_pkg::S_FILL:
                if (r_addr == r_end) n_state = r_after_roll ? cwtg_pkg::S_PEN :
                    (r_bs ? cwtg_pkg::S_BS_BLANK : cwtg_pkg::S_OUT);
            cwtg_pkg::S_ROLL_RD: n_state = cwtg_pkg::S_ROLL_WR;
            cwtg_pkg::S_ROLL_WR:
                if (r_rc + 7'd1 >= cc_u && r_rr + 5'd1 >= rr_u - 5'd1)
                    n_state = cwtg_pkg::S_FILL;
                else n_state = cwtg_pkg::S_ROLL_RD;
            cwtg_pkg::S_MOVE:
                if (mv_roll) n_state = (rr_u > 5'd1) ? cwtg_pkg::S_ROLL_RD
                                                     : cwtg_pkg::S_FILL;
                else if (r_bs) n_state = cwtg_pkg::S_BS_BLANK;
                else n_state = cwtg_pkg::S_OUT;
            cwtg_pkg::S_BS_BLANK: n_state = cwtg_pkg::S_OUT;
            cwtg_pkg::S_PEN:  n_state = cwtg_pkg::S_OUT;
            cwtg_pkg::S_READ: n_state = cwtg_pkg::S_OUT;
            cwtg_pkg::S_OUT:
                if (m_axis_tready) n_state = cwtg_pkg::S_IDLE;
            default: n_state = cwtg_pkg::S_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb begin
        n_addr = r_addr; n_end = r_end; n_rr = r_rr; n_rc = r_rc;
        n_chg = r_chg; n_after_roll = r_after_roll; n_bs = r_bs;
        n_pen_row = r_pen_row; n_pen_col = r_pen_col;
        n_ochar = r_ochar; n_oattr = r_oattr;
        m_we = 1'b0;
        m_addr = r_addr[AW-1:0];
        m_wdata = {r_attr, cwtg_pkg::SPACE};
        s_axis_tready = (r_state == cwtg_pkg::S_IDLE);
        unique case (r_state)
            cwtg_pkg::S_INIT: begin
                m_we = 1'b1;
                m_wdata = {{cwtg_pkg::ATTR_W{1'b0}}, cwtg_pkg::SPACE};
                n_addr = r_addr + 1'b1;
            end
            cwtg_pkg::S_IDLE: begin
                n_chg = 1'b0; n_after_roll = 1'b0; n_bs = 1'b0;
                n_ochar = '0; n_oattr = '0;
            end
            cwtg_pkg::S_DECODE: begin
                n_rr = '0; n_rc = '0;
                // last-row blank range for a roll
                n_addr = (AW+1)'(rr_u - 5'd1) * (AW+1)'(cwtg_pkg::MAX_COLUMNS);
                n_end  = n_addr + (AW+1)'(cc_u) - 1'b1;
                if (r_kind == cwtg_pkg::KIND_READ) begin
                    m_addr = {r_trow, r_tcol};
                end else if (r_def) begin
                    if (r_kind == cwtg_pkg::KIND_CLEAR) begin
                        n_chg = 1'b1;
                        n_addr = '0; n_end = (AW+1)'(cwtg_pkg::CELLS - 1);
                    end else if (r_kind == cwtg_pkg::KIND_PEN) begin
                        n_after_roll = 1'b1;
                        if (scroll_bt && (r_trow == '0 || {1'b0, r_trow} >= rr_u))
                            n_chg = 1'b1;
                    end else if (in_win) begin
                        n_chg = 1'b1;
                        priority if (r_code == cwtg_pkg::CODE_CR) begin
                            n_pen_col = '0;
                            if (!(scroll_bt && r_pen_row + 5'd1 >= rr_u))
                                n_pen_row = r_pen_row + 5'd1;
                        end else if (r_code == cwtg_pkg::CODE_HCR) begin
                            n_pen_col = '0;
                            n_addr = (AW+1)'(pen_addr) - (AW+1)'(r_pen_col);
                            n_end = n_addr + (AW+1)'(cc_u) - 1'b1;
                        end else if (r_code == cwtg_pkg::CODE_FF) begin
                            n_pen_row = '0; n_pen_col = '0;
                            n_addr = '0; n_end = (AW+1)'(cwtg_pkg::CELLS - 1);
                        end else if (r_code == cwtg_pkg::CODE_BS) begin
                            n_bs = 1'b1;
                        end else begin
                            m_we = 1'b1;
                            m_addr = pen_addr;
                            m_wdata = {r_attr, r_code};
                        end
                    end
                end
            end
            cwtg_pkg::S_FILL: begin
                m_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            cwtg_pkg::S_ROLL_RD: begin
                m_addr = AW'(rr_base + (AW+1)'(cwtg_pkg::MAX_COLUMNS));
            end
            cwtg_pkg::S_ROLL_WR: begin
                m_we = 1'b1;
                m_addr = rr_base[AW-1:0];
                m_wdata = r_rdata;
                if (r_rc + 7'd1 >= cc_u) begin
                    n_rc = '0; n_rr = r_rr + 1'b1;
                end else n_rc = r_rc + 1'b1;
            end
            cwtg_pkg::S_MOVE: begin
                if (mv_roll) begin
                    n_pen_row = rr_u - 5'd1;
                    n_pen_col = lim_c[5:0];
                end else begin
                    n_pen_row = lim_r[4:0];
                    n_pen_col = lim_c[5:0];
                end
            end
            cwtg_pkg::S_BS_BLANK: begin
                m_we = 1'b1;
                m_addr = pen_addr;
            end
            cwtg_pkg::S_PEN: begin
                n_pen_row = (r_chg && r_trow != '0) ? rr_u - 5'd1 :
                            ({1'b0, r_trow} > rr_u - 5'd1) ? rr_u - 5'd1 : {1'b0, r_trow};
                n_pen_col = ({1'b0, r_tcol} > cc_u - 7'd1) ? 6'(cc_u - 7'd1) : r_tcol;
            end
            cwtg_pkg::S_READ: begin
                n_ochar = r_rdata[cwtg_pkg::CHAR_W-1:0];
                n_oattr = r_rdata[cwtg_pkg::CELL_W-1:cwtg_pkg::CHAR_W];
            end
            cwtg_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwtg_pkg::S_INIT;
            r_addr <= '0;
            r_end <= (AW+1)'(cwtg_pkg::CELLS - 1);
            r_pen_row <= '0; r_pen_col <= '0;
            r_chg <= 1'b0; r_after_roll <= 1'b0; r_bs <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr; r_end <= n_end;
            r_pen_row <= n_pen_row; r_pen_col <= n_pen_col;
            r_chg <= n_chg; r_after_roll <= n_after_roll; r_bs <= n_bs;
        end
        r_rr <= n_rr; r_rc <= n_rc;
        r_ochar <= n_ochar; r_oattr <= n_oattr;
    end

    assign m_axis_tvalid = (r_state == cwtg_pkg::S_OUT);
    assign m_axis_tdata = {5'd0, r_chg, r_pen_col, r_pen_row, r_oattr, r_ochar};
endmodule

// File: tb/tb.sv
// Testbench for caption_window_text_grid: drives caption commands over the
// stream input, predicts each result with a behavioral grid model and checks it.
// Depends on cwtg_pkg and caption_window_text_grid.
module tb;
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code;
        logic [38:0] attr;
        logic [3:0]  row;
        logic [5:0]  col;
    } t_cmd;

    typedef struct packed {
        logic [15:0] ch;
        logic [38:0] attr;
        logic [4:0]  prow;
        logic [5:0]  pcol;
        logic        changed;
    } t_res;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;

    caption_window_text_grid i_dut (.*);

    // predictor state
    logic [15:0] grid_ch [cwtg_pkg::CELLS];
    logic [38:0] grid_at [cwtg_pkg::CELLS];
    int pen_r, pen_c;
    int cfg_rows, cfg_cols, cfg_print, cfg_scroll, cfg_lrows, cfg_lcols, cfg_def;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int mismatches = 0;
    int src_idle = 0, sink_stall = 0;
    bit sink_hold = 0;
    bit hold_start = 0;
    bit in_fire = 0;
    longint cycles = 0;

    initial forever #6 i_clk = ~i_clk;

    function automatic int rows_used();
        return cfg_rows < 1 ? 1 :
               (cfg_rows > cwtg_pkg::MAX_ROWS ? cwtg_pkg::MAX_ROWS : cfg_rows);
    endfunction
    function automatic int cols_used();
        return cfg_cols < 1 ? 1 :
               (cfg_cols > cwtg_pkg::MAX_COLUMNS ? cwtg_pkg::MAX_COLUMNS : cfg_cols);
    endfunction

    function automatic void blank_all(logic [38:0] a);
        for (int i = 0; i < cwtg_pkg::CELLS; i++) begin
            grid_ch[i] = cwtg_pkg::SPACE;
            grid_at[i] = a;
        end
    endfunction

    function automatic void scroll_up(logic [38:0] a);
        int rr, cc;
        rr = rows_used();
        cc = cols_used();
        for (int r = 0; r + 1 < rr; r++)
            for (int c = 0; c < cc; c++) begin
                grid_ch[r*cwtg_pkg::MAX_COLUMNS+c] = grid_ch[(r+1)*cwtg_pkg::MAX_COLUMNS+c];
                grid_at[r*cwtg_pkg::MAX_COLUMNS+c] = grid_at[(r+1)*cwtg_pkg::MAX_COLUMNS+c];
            end
        for (int c = 0; c < cc; c++) begin
            grid_ch[(rr-1)*cwtg_pkg::MAX_COLUMNS+c] = cwtg_pkg::SPACE;
            grid_at[(rr-1)*cwtg_pkg::MAX_COLUMNS+c] = a;
        end
    endfunction

    function automatic void place_pen(int nr, int nc);
        int rr, cc;
        rr = rows_used();
        cc = cols_used();
        pen_r = (nr < 0 || nr > rr - 1) ? rr - 1 : nr;
        pen_c = (nc < 0 || nc > cc - 1) ? cc - 1 : nc;
    endfunction

    function automatic void step_pen(bit fwd, logic [38:0] a);
        int rr, cc, nr, nc, s;
        rr = rows_used();
        cc = cols_used();
        nr = pen_r;
        nc = pen_c;
        s = fwd ? 1 : -1;
        case (cfg_print)
            0: nc += s;
            1: nc -= s;
            2: nr += s;
            default: nr -= s;
        endcase
        if (cfg_print < 2) begin
            if (!cfg_lrows && cfg_lcols) begin
                if (nc >= cc) begin
                    nc = 0;
                    nr += 1;
                end else if (nc < 0) begin
                    nc = cc - 1;
                    nr -= 1;
                end
            end
            if (cfg_scroll == cwtg_pkg::DIR_BT && nr >= rr) begin
                scroll_up(a);
                nr = rr - 1;
            end
            place_pen(nr, nc);
        end else begin
            place_pen(nr < 0 ? 0 : nr, nc < 0 ? 0 : nc);
        end
    endfunction

    function automatic t_res grid_step(t_cmd t);
        t_res o;
        int rr, cc, i, row, pi;
        o = '0;
        rr = rows_used();
        cc = cols_used();
        if (t.kind == cwtg_pkg::KIND_READ) begin
            i = t.row * cwtg_pkg::MAX_COLUMNS + t.col;
            o.ch = grid_ch[i];
            o.attr = grid_at[i];
        end else if (cfg_def) begin
            if (t.kind == cwtg_pkg::KIND_ADD) begin
                if (pen_r < rr && pen_c < cc) begin
                    o.changed = 1;
                    if (t.code == cwtg_pkg::CODE_CR) begin
                        if (cfg_scroll == cwtg_pkg::DIR_BT && pen_r + 1 >= rr) begin
                            scroll_up(t.attr);
                            pen_r = rr - 1;
                        end else pen_r++;
                        pen_c = 0;
                    end else if (t.code == cwtg_pkg::CODE_HCR) begin
                        for (int c = 0; c < cc; c++) begin
                            grid_ch[pen_r*cwtg_pkg::MAX_COLUMNS+c] = cwtg_pkg::SPACE;
                            grid_at[pen_r*cwtg_pkg::MAX_COLUMNS+c] = t.attr;
                        end
                        pen_c = 0;
                    end else if (t.code == cwtg_pkg::CODE_BS) begin
                        step_pen(0, t.attr);
                        pi = pen_r * cwtg_pkg::MAX_COLUMNS + pen_c;
                        grid_ch[pi] = cwtg_pkg::SPACE;
                        grid_at[pi] = t.attr;
                    end else if (t.code == cwtg_pkg::CODE_FF) begin
                        blank_all(t.attr);
                        pen_r = 0;
                        pen_c = 0;
                    end else begin
                        pi = pen_r * cwtg_pkg::MAX_COLUMNS + pen_c;
                        grid_ch[pi] = t.code;
                        grid_at[pi] = t.attr;
                        step_pen(1, t.attr);
                    end
                end
            end else if (t.kind == cwtg_pkg::KIND_PEN) begin
                row = t.row;
                if (cfg_scroll == cwtg_pkg::DIR_BT && (row == 0 || row >= rr)) begin
                    scroll_up(t.attr);
                    o.changed = 1;
                    if (row != 0) row = rr - 1;
                end
                place_pen(row, t.col);
            end else begin
                blank_all(t.attr);
                o.changed = 1;
            end
        end
        o.prow = 5'(pen_r);
        o.pcol = 6'(pen_c);
        return o;
    endfunction

    // input accept seen at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge i_clk) begin
        t_res pred;
        if (in_fire) begin
            pred = grid_step(pending_cmds.pop_front());
            expected_results = {expected_results, pred};
        end
        if (in_fire || !s_axis_tvalid) begin
            if (pending_cmds.size() > 0 && ($urandom_range(99) >= src_idle)) begin
                s_axis_tvalid <= 1;
                s_axis_tdata <= {7'd0, pending_cmds[0].col, pending_cmds[0].row,
                                 pending_cmds[0].attr, pending_cmds[0].code};
                s_axis_tuser <= pending_cmds[0].kind;
            end else begin
                s_axis_tvalid <= 0;
            end
        end
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall);
    end

    // long receiver hold
    initial begin
        wait (hold_start);
        sink_hold = 1;
        repeat (400) @(posedge i_clk);
        sink_hold = 0;
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[54:16], m_axis_tdata[59:55],
                   m_axis_tdata[65:60], m_axis_tdata[66]};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ch=%h at=%h r=%0d c=%0d chg=%b, ",
                                  "got ch=%h at=%h r=%0d c=%0d chg=%b"},
                                 exp_r.ch, exp_r.attr, exp_r.prow, exp_r.pcol,
                                 exp_r.changed, got.ch, got.attr, got.prow, got.pcol,
                                 got.changed);
                end
            end
        end
        if (cycles > 10000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cwtg_pkg::REG_ROWS:   cfg_rows = val[4:0];
            cwtg_pkg::REG_COLS:   cfg_cols = val;
            cwtg_pkg::REG_PRINT:  cfg_print = val[1:0];
            cwtg_pkg::REG_SCROLL: cfg_scroll = val[1:0];
            cwtg_pkg::REG_LROWS:  cfg_lrows = val[0];
            cwtg_pkg::REG_LCOLS:  cfg_lcols = val[0];
            default:              cfg_def = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    function automatic void push_cmd(logic [1:0] k, logic [15:0] code, logic [38:0] a,
                                     logic [3:0] r, logic [5:0] c);
        t_cmd t;
        t.kind = k; t.code = code; t.attr = a; t.row = r; t.col = c;
        pending_cmds = {pending_cmds, t};
    endfunction

    function automatic logic [38:0] rand_attr();
        return 39'({$urandom_range(127), $urandom()});
    endfunction

    function automatic logic [15:0] rand_code();
        logic [15:0] pick[4] = '{cwtg_pkg::CODE_CR, cwtg_pkg::CODE_HCR,
                                 cwtg_pkg::CODE_BS, cwtg_pkg::CODE_FF};
        if ($urandom_range(99) < 25) return pick[$urandom_range(3)];
        if ($urandom_range(9) == 0) return 16'($urandom());
        return 16'(16'h20 + $urandom_range(94));
    endfunction

    // mostly text with pen moves and reads; clears are rare as they are slow
    function automatic void random_cmds(int n);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 55)
                push_cmd(cwtg_pkg::KIND_ADD, rand_code(), rand_attr(),
                         4'($urandom()), 6'($urandom()));
            else if (p < 70)
                push_cmd(cwtg_pkg::KIND_PEN, 16'($urandom()), rand_attr(),
                         4'($urandom()), 6'($urandom()));
            else if (p < 98)
                push_cmd(cwtg_pkg::KIND_READ, 16'($urandom()), rand_attr(),
                         4'($urandom()), 6'($urandom()));
            else
                push_cmd(cwtg_pkg::KIND_CLEAR, 16'($urandom()), rand_attr(),
                         4'($urandom()), 6'($urandom()));
        end
    endfunction

    task automatic random_setting(bit extreme);
        write_reg(cwtg_pkg::REG_ROWS,
                  extreme ? ($urandom_range(1) ? 7'd0 : 7'd31) : 7'($urandom_range(1, 16)));
        write_reg(cwtg_pkg::REG_COLS,
                  extreme ? ($urandom_range(1) ? 7'd0 : 7'd127) : 7'($urandom_range(1, 64)));
        write_reg(cwtg_pkg::REG_PRINT, 7'($urandom_range(3)));
        write_reg(cwtg_pkg::REG_SCROLL, 7'($urandom_range(3)));
        write_reg(cwtg_pkg::REG_LROWS, 7'($urandom_range(1)));
        write_reg(cwtg_pkg::REG_LCOLS, 7'($urandom_range(1)));
        write_reg(cwtg_pkg::REG_DEF, 7'($urandom_range(9) != 0));
    endtask

    initial begin
        blank_all('0);
        pen_r = 0; pen_c = 0;
        cfg_rows = 15; cfg_cols = 32; cfg_print = 0; cfg_scroll = 3;
        cfg_lrows = 0; cfg_lcols = 1; cfg_def = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: window undefined, then basic operations and control codes
        push_cmd(cwtg_pkg::KIND_ADD, 16'h41, '1, 0, 0);
        push_cmd(cwtg_pkg::KIND_READ, 0, 0, 4'hF, 6'h3F);
        drain();
        write_reg(cwtg_pkg::REG_DEF, 1);
        write_reg(cwtg_pkg::REG_ROWS, 2);
        write_reg(cwtg_pkg::REG_COLS, 3);
        push_cmd(cwtg_pkg::KIND_ADD, 16'hFFFF, '1, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, 16'h0000, '0, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, 16'h42, 39'h2AAAAAAAAA, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, 16'h43, 39'h5555555555, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_BS, 39'h1, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_CR, 39'h2, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_CR, 39'h3, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_HCR, 39'h4, 0, 0);
        push_cmd(cwtg_pkg::KIND_PEN, 0, 39'h5, 4'hF, 6'h3F);
        push_cmd(cwtg_pkg::KIND_PEN, 0, 39'h6, 4'h0, 6'h01);
        push_cmd(cwtg_pkg::KIND_READ, 0, 0, 0, 0);
        push_cmd(cwtg_pkg::KIND_READ, 0, 0, 1, 2);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_FF, 39'h7, 0, 0);
        push_cmd(cwtg_pkg::KIND_CLEAR, 0, 39'h8, 0, 0);
        push_cmd(cwtg_pkg::KIND_READ, 0, 0, 4'hF, 6'h3F);
        drain();
        write_reg(cwtg_pkg::REG_SCROLL, 0);
        write_reg(cwtg_pkg::REG_PRINT, 1);
        write_reg(cwtg_pkg::REG_LROWS, 1);
        write_reg(cwtg_pkg::REG_LCOLS, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_BS, 39'h9, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_CR, 39'hA, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, cwtg_pkg::CODE_CR, 39'hB, 0, 0);
        push_cmd(cwtg_pkg::KIND_ADD, 16'h44, 39'hC, 0, 0);
        push_cmd(cwtg_pkg::KIND_PEN, 0, 39'hD, 4'h9, 6'h20);
        drain();

        // random phases with differing flow control
        for (int ph = 0; ph < 8; ph++) begin
            random_setting(ph < 2);
            case (ph % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 88; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 88; end
                default: begin src_idle = 29; sink_stall = 29; end
            endcase
            random_cmds(35);
            if (ph == 2) begin
                repeat (30) @(posedge i_clk);
                hold_start = 1;
            end
            drain();
            random_cmds(35);
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
